// ----- hw/rtl/dprk4_pkg.sv -----
package dprk4_pkg;

    localparam int DATA_W  = 32;
    localparam int FRAC_W  = 24;
    localparam int CFG_W   = 31;
    localparam int COEF_W  = 31;
    localparam int DT_W    = 24;
    localparam int IDX_W   = 2;
    localparam int MUL_W   = 35;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int ACC_W   = 36;
    localparam int WIDE_W  = 48;
    localparam int SIN_SH  = 30 - FRAC_W;
    localparam int SEQ_LEN = 23;
    localparam int CNT_W   = 5;
    localparam int DSEL_W  = 3;

    localparam logic [IDX_W-1:0] CFG_STIFF   = 2'd0;
    localparam logic [IDX_W-1:0] CFG_DAMPING = 2'd1;
    localparam logic [IDX_W-1:0] CFG_DT      = 2'd2;
    localparam logic [IDX_W-1:0] CFG_ENABLED = 2'd3;

    localparam logic [COEF_W-1:0] STIFF_RST = 31'd16777216;
    localparam logic [DT_W-1:0]   DT_RST    = 24'd16777;

    // 1/(2 pi) in Q0.32, pi/2 in Q2.30, 2^34/3 for the final divide by six
    localparam logic [29:0] INV_TWO_PI = 30'd683565276;
    localparam logic [30:0] HALF_PI    = 31'd1686629713;
    localparam logic [32:0] RECIP3     = 33'd5726623061;

    localparam logic [DSEL_W-1:0] DIV_110 = 3'd0;
    localparam logic [DSEL_W-1:0] DIV_72  = 3'd1;
    localparam logic [DSEL_W-1:0] DIV_42  = 3'd2;
    localparam logic [DSEL_W-1:0] DIV_20  = 3'd3;
    localparam logic [DSEL_W-1:0] DIV_6   = 3'd4;

    typedef enum logic [4:0] {
        OP_NOP, OP_LOAD, OP_INIT, OP_PHASE, OP_QUAD, OP_XSQ, OP_X2, OP_CORR,
        OP_TMUL, OP_VMUL, OP_SXT, OP_SIN, OP_DAMP, OP_DR, OP_KA, OP_KR,
        OP_DIVA, OP_FINA, OP_FINR, OP_OUT
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE, ST_RUN, ST_DIVA, ST_FINA, ST_FINR, ST_DONE
    } t_state;

    typedef struct packed {
        t_op               op;
        logic [DSEL_W-1:0] dsel;
        logic [1:0]        stage;
    } t_cmd;

    typedef struct packed {
        logic enabled;
    } t_status;

    typedef struct packed {
        t_op               op;
        logic [DSEL_W-1:0] dsel;
    } t_uop;

    // one rk4 stage: sine by taylor series, then the derivative and k terms
    function automatic t_uop seq_rom(input logic [CNT_W-1:0] idx);
        t_uop u;
        u.dsel = DIV_110;
        case (idx)
            5'd0:  u.op = OP_PHASE;
            5'd1:  u.op = OP_QUAD;
            5'd2:  u.op = OP_XSQ;
            5'd3:  u.op = OP_X2;
            5'd4:  u.op = OP_CORR;
            5'd5:  u.op = OP_TMUL;
            5'd6:  begin u.op = OP_VMUL; u.dsel = DIV_72; end
            5'd7:  begin u.op = OP_CORR; u.dsel = DIV_72; end
            5'd8:  u.op = OP_TMUL;
            5'd9:  begin u.op = OP_VMUL; u.dsel = DIV_42; end
            5'd10: begin u.op = OP_CORR; u.dsel = DIV_42; end
            5'd11: u.op = OP_TMUL;
            5'd12: begin u.op = OP_VMUL; u.dsel = DIV_20; end
            5'd13: begin u.op = OP_CORR; u.dsel = DIV_20; end
            5'd14: u.op = OP_TMUL;
            5'd15: begin u.op = OP_VMUL; u.dsel = DIV_6; end
            5'd16: begin u.op = OP_CORR; u.dsel = DIV_6; end
            5'd17: u.op = OP_SXT;
            5'd18: u.op = OP_SIN;
            5'd19: u.op = OP_DAMP;
            5'd20: u.op = OP_DR;
            5'd21: u.op = OP_KA;
            5'd22: u.op = OP_KR;
            default: u.op = OP_NOP;
        endcase
        return u;
    endfunction

    function automatic logic [6:0] div_const(input logic [DSEL_W-1:0] s);
        case (s)
            DIV_110: return 7'd110;
            DIV_72:  return 7'd72;
            DIV_42:  return 7'd42;
            DIV_20:  return 7'd20;
            DIV_6:   return 7'd6;
            default: return 7'd6;
        endcase
    endfunction

    // floor(2^32 / d), low by at most one after the shift
    function automatic logic [29:0] div_recip(input logic [DSEL_W-1:0] s);
        case (s)
            DIV_110: return 30'd39045157;
            DIV_72:  return 30'd59652323;
            DIV_42:  return 30'd102261126;
            DIV_20:  return 30'd214748364;
            DIV_6:   return 30'd715827882;
            default: return 30'd715827882;
        endcase
    endfunction

endpackage

// ----- hw/rtl/dprk4_ctrl.sv -----
module dprk4_ctrl
    import dprk4_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_mode,
    output logic    o_stall,
    output logic    o_valid,
    input  logic    i_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [1:0]         r_stage, n_stage;
    logic               r_o_valid, n_o_valid;
    logic               cap;
    t_uop               uop;

    assign cap     = (r_state == ST_DONE) && (!r_o_valid || !i_stall);
    assign uop     = seq_rom(r_cnt);
    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_o_valid;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_stage   = r_stage;
        n_o_valid = cap ? 1'b1 : (r_o_valid & i_stall);
        case (r_state)
            ST_IDLE: begin
                n_cnt   = '0;
                n_stage = '0;
                if (i_valid) begin
                    if (i_mode || !i_status.enabled) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (r_cnt == CNT_W'(SEQ_LEN - 1)) begin
                    n_cnt = '0;
                    if (r_stage == 2'd3) begin
                        n_state = ST_DIVA;
                    end else begin
                        n_stage = r_stage + 2'd1;
                    end
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            ST_DIVA: n_state = ST_FINA;
            ST_FINA: n_state = ST_FINR;
            ST_FINR: n_state = ST_DONE;
            ST_DONE: begin
                if (cap) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op    = OP_NOP;
        o_cmd.dsel  = uop.dsel;
        o_cmd.stage = r_stage;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_mode) begin
                        o_cmd.op = OP_LOAD;
                    end else if (i_status.enabled) begin
                        o_cmd.op = OP_INIT;
                    end
                end
            end
            ST_RUN:  o_cmd.op = uop.op;
            ST_DIVA: o_cmd.op = OP_DIVA;
            ST_FINA: o_cmd.op = OP_FINA;
            ST_FINR: o_cmd.op = OP_FINR;
            ST_DONE: begin
                if (cap) begin
                    o_cmd.op = OP_OUT;
                end
            end
            default: o_cmd.op = OP_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_stage   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_stage   <= n_stage;
            r_o_valid <= n_o_valid;
        end
    end

endmodule

// ----- hw/rtl/dprk4_dp.sv -----
module dprk4_dp
    import dprk4_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_status                  o_status,
    input  logic                     i_cfg_wr_en,
    input  logic [IDX_W-1:0]         i_cfg_addr,
    input  logic [CFG_W-1:0]         i_cfg_wdata,
    input  logic signed [DATA_W-1:0] i_new_angle,
    input  logic signed [DATA_W-1:0] i_new_rate,
    output logic signed [DATA_W-1:0] o_angle,
    output logic signed [DATA_W-1:0] o_rate
);

    localparam logic signed [WIDE_W-1:0] SAT_MAX = (WIDE_W'(1) <<< (DATA_W - 1)) - WIDE_W'(1);
    localparam logic signed [WIDE_W-1:0] SAT_MIN = -SAT_MAX - WIDE_W'(1);
    localparam logic signed [ACC_W-1:0]  G_OFS   = ACC_W'(64'd6442450944);
    localparam logic signed [ACC_W-1:0]  Q_OFS   = ACC_W'(64'd2147483648);
    localparam logic [32:0]              SIN_RND = 33'((1 << SIN_SH) >> 1);
    localparam logic [32:0]              ONE_Q30 = 33'd1 << 30;

    function automatic logic signed [DATA_W-1:0] sat_dw(input logic signed [WIDE_W-1:0] v);
        if (v > SAT_MAX) begin
            return DATA_W'(SAT_MAX);
        end else if (v < SAT_MIN) begin
            return DATA_W'(SAT_MIN);
        end
        return DATA_W'(v);
    endfunction

    function automatic logic signed [MUL_W-1:0] ext_u(input logic [MUL_W-2:0] v);
        return $signed({1'b0, v});
    endfunction

    // configuration
    logic [COEF_W-1:0] r_stiff, r_damping;
    logic [DT_W-1:0]   r_dt;
    logic              r_enabled;

    // state and working registers
    logic signed [DATA_W-1:0] r_ang, n_ang, r_rte, n_rte;
    logic signed [DATA_W-1:0] r_pa, n_pa, r_pr, n_pr;
    logic signed [DATA_W-1:0] r_ka, n_ka, r_dr, n_dr;
    logic signed [DATA_W-1:0] r_out_a, n_out_a, r_out_r, n_out_r;
    logic signed [ACC_W-1:0]  r_acc_a, n_acc_a, r_acc_r, n_acc_r;
    logic signed [WIDE_W-1:0] r_stf, n_stf;
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic [1:0]               r_quad, n_quad;
    logic [31:0]              r_x, n_x, r_x2, n_x2, r_v, n_v, r_t, n_t;
    logic [33:0]              r_g, n_g;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic                     mul_en;

    logic signed [WIDE_W-1:0] sh_f;
    logic [31:0]              hi30, phase;
    logic [30:0]              mirr;
    logic [6:0]               dv;
    logic [31:0]              q0;
    logic [39:0]              rem;
    logic [32:0]              q, s_rnd;
    logic signed [MUL_W-1:0]  sin_v;
    logic signed [DATA_W-1:0] kr, ka_h, kr_h;
    logic signed [ACC_W-1:0]  g_a, g_r, quot, rem3;
    logic [33:0]              q3;

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign sh_f  = WIDE_W'(r_prod >>> FRAC_W);
    assign hi30  = r_prod[61:30];
    assign phase = r_prod[FRAC_W+31:FRAC_W];
    assign mirr  = phase[30] ? 31'(ONE_Q30 - 33'(phase[29:0])) : 31'(phase[29:0]);
    assign dv    = div_const(i_cmd.dsel);
    assign q0    = r_prod[63:32];
    assign rem   = 40'(r_v) - 40'(q0) * 40'(dv);
    assign q     = 33'(q0) + 33'(rem >= 40'(dv));
    assign s_rnd = (33'(hi30) + SIN_RND) >> SIN_SH;
    assign sin_v = (r_quad[1]) ? -MUL_W'(s_rnd) : MUL_W'(s_rnd);
    assign kr    = sat_dw(sh_f);
    assign ka_h  = (i_cmd.stage == 2'd2) ? r_ka : (r_ka >>> 1);
    assign kr_h  = (i_cmd.stage == 2'd2) ? kr : (kr >>> 1);
    // offset makes the halved sum non-negative for the reciprocal divide by three
    assign g_a   = (r_acc_a >>> 1) + G_OFS;
    assign g_r   = (r_acc_r >>> 1) + G_OFS;
    assign q3    = r_prod[67:34];
    assign rem3  = ACC_W'(r_g) - ACC_W'(q3) * ACC_W'(3);
    assign quot  = ACC_W'(q3) + ACC_W'(rem3 >= ACC_W'(3)) - Q_OFS;

    always_comb begin
        n_ang   = r_ang;
        n_rte   = r_rte;
        n_pa    = r_pa;
        n_pr    = r_pr;
        n_ka    = r_ka;
        n_dr    = r_dr;
        n_out_a = r_out_a;
        n_out_r = r_out_r;
        n_acc_a = r_acc_a;
        n_acc_r = r_acc_r;
        n_stf   = r_stf;
        n_quad  = r_quad;
        n_x     = r_x;
        n_x2    = r_x2;
        n_v     = r_v;
        n_t     = r_t;
        n_g     = r_g;
        mul_en  = 1'b0;
        mul_a   = '0;
        mul_b   = '0;
        case (i_cmd.op)
            OP_LOAD: begin
                n_ang = i_new_angle;
                n_rte = i_new_rate;
            end
            OP_INIT: begin
                n_pa    = r_ang;
                n_pr    = r_rte;
                n_acc_a = '0;
                n_acc_r = '0;
            end
            OP_PHASE: begin
                mul_en = 1'b1;
                mul_a  = MUL_W'(r_pa);
                mul_b  = ext_u(34'(INV_TWO_PI));
            end
            OP_QUAD: begin
                n_quad = phase[31:30];
                mul_en = 1'b1;
                mul_a  = ext_u(34'(mirr));
                mul_b  = ext_u(34'(HALF_PI));
            end
            OP_XSQ: begin
                n_x    = hi30;
                mul_en = 1'b1;
                mul_a  = ext_u(34'(hi30));
                mul_b  = ext_u(34'(hi30));
            end
            OP_X2: begin
                n_x2   = hi30;
                n_v    = hi30;
                mul_en = 1'b1;
                mul_a  = ext_u(34'(hi30));
                mul_b  = ext_u(34'(div_recip(i_cmd.dsel)));
            end
            OP_CORR: begin
                n_t = 32'(ONE_Q30 - q);
            end
            OP_TMUL: begin
                mul_en = 1'b1;
                mul_a  = ext_u(34'(r_x2));
                mul_b  = ext_u(34'(r_t));
            end
            OP_VMUL: begin
                n_v    = hi30;
                mul_en = 1'b1;
                mul_a  = ext_u(34'(hi30));
                mul_b  = ext_u(34'(div_recip(i_cmd.dsel)));
            end
            OP_SXT: begin
                mul_en = 1'b1;
                mul_a  = ext_u(34'(r_x));
                mul_b  = ext_u(34'(r_t));
            end
            OP_SIN: begin
                mul_en = 1'b1;
                mul_a  = ext_u(34'(r_stiff));
                mul_b  = sin_v;
            end
            OP_DAMP: begin
                n_stf  = sh_f;
                mul_en = 1'b1;
                mul_a  = ext_u(34'(r_damping));
                mul_b  = MUL_W'(r_pr);
            end
            OP_DR: begin
                n_dr   = sat_dw(-(sh_f <<< 1) - r_stf);
                mul_en = 1'b1;
                mul_a  = MUL_W'(r_pr);
                mul_b  = ext_u(34'(r_dt));
            end
            OP_KA: begin
                n_ka   = sat_dw(sh_f);
                mul_en = 1'b1;
                mul_a  = MUL_W'(r_dr);
                mul_b  = ext_u(34'(r_dt));
            end
            OP_KR: begin
                // middle stages carry weight two
                if (i_cmd.stage == 2'd1 || i_cmd.stage == 2'd2) begin
                    n_acc_a = r_acc_a + (ACC_W'(r_ka) <<< 1);
                    n_acc_r = r_acc_r + (ACC_W'(kr) <<< 1);
                end else begin
                    n_acc_a = r_acc_a + ACC_W'(r_ka);
                    n_acc_r = r_acc_r + ACC_W'(kr);
                end
                n_pa = sat_dw(WIDE_W'(r_ang) + WIDE_W'(ka_h));
                n_pr = sat_dw(WIDE_W'(r_rte) + WIDE_W'(kr_h));
            end
            OP_DIVA: begin
                n_g    = g_a[33:0];
                mul_en = 1'b1;
                mul_a  = ext_u(g_a[33:0]);
                mul_b  = ext_u(34'(RECIP3));
            end
            OP_FINA: begin
                n_ang  = sat_dw(WIDE_W'(r_ang) + WIDE_W'(quot));
                n_g    = g_r[33:0];
                mul_en = 1'b1;
                mul_a  = ext_u(g_r[33:0]);
                mul_b  = ext_u(34'(RECIP3));
            end
            OP_FINR: begin
                n_rte = sat_dw(WIDE_W'(r_rte) + WIDE_W'(quot));
            end
            OP_OUT: begin
                n_out_a = r_ang;
                n_out_r = r_rte;
            end
            default: ;
        endcase
        n_prod = mul_en ? mul_p : r_prod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stiff   <= STIFF_RST;
            r_damping <= '0;
            r_dt      <= DT_RST;
            r_enabled <= 1'b0;
            r_ang     <= '0;
            r_rte     <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    CFG_STIFF:   r_stiff   <= i_cfg_wdata;
                    CFG_DAMPING: r_damping <= i_cfg_wdata;
                    CFG_DT:      r_dt      <= i_cfg_wdata[DT_W-1:0];
                    CFG_ENABLED: r_enabled <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
            r_ang <= n_ang;
            r_rte <= n_rte;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pa    <= n_pa;
        r_pr    <= n_pr;
        r_ka    <= n_ka;
        r_dr    <= n_dr;
        r_out_a <= n_out_a;
        r_out_r <= n_out_r;
        r_acc_a <= n_acc_a;
        r_acc_r <= n_acc_r;
        r_stf   <= n_stf;
        r_prod  <= n_prod;
        r_quad  <= n_quad;
        r_x     <= n_x;
        r_x2    <= n_x2;
        r_v     <= n_v;
        r_t     <= n_t;
        r_g     <= n_g;
    end

    assign o_status.enabled = r_enabled;
    assign o_angle          = r_out_a;
    assign o_rate           = r_out_r;

endmodule

// ----- hw/rtl/damped_pendulum_rk4_step.sv -----
// channel   direction  handshake          payload
// input     in         i_valid / o_stall  i_mode, i_new_angle, i_new_rate
// result    out        o_valid / i_stall  o_angle, o_rate
// config    in         i_cfg_wr_en        i_cfg_addr, i_cfg_wdata
//
// a step transaction runs four rk4 stages through the sequence rom on the single
// shared multiplier, then the diva, fina and finr states for the divide by six
// and the state update. loads and disabled steps go straight to the result state.
// reset is synchronous: state zero, configuration registers to their defaults.
// a waiting result sits in the output register while the next transaction runs.
module damped_pendulum_rk4_step
    import dprk4_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_mode,
    input  logic signed [DATA_W-1:0] i_new_angle,
    input  logic signed [DATA_W-1:0] i_new_rate,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [DATA_W-1:0] o_angle,
    output logic signed [DATA_W-1:0] o_rate,
    input  logic                     i_cfg_wr_en,
    input  logic [IDX_W-1:0]         i_cfg_addr,
    input  logic [CFG_W-1:0]         i_cfg_wdata
);

    t_cmd    cmd;
    t_status status;

    dprk4_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_mode   (i_mode),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    dprk4_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_new_angle (i_new_angle),
        .i_new_rate  (i_new_rate),
        .o_angle     (o_angle),
        .o_rate      (o_rate)
    );

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import dprk4_pkg::*;

    typedef struct {
        logic                     mode;
        logic signed [DATA_W-1:0] ang;
        logic signed [DATA_W-1:0] rt;
    } t_pend_item;

    typedef struct {
        logic signed [DATA_W-1:0] ang;
        logic signed [DATA_W-1:0] rt;
    } t_pend_state;

    localparam int WDOG_LIMIT = 5000;
    localparam int HOLD_LEN   = 400;
    localparam logic MODE_STEP = 1'b0;
    localparam logic MODE_LOAD = 1'b1;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic                     in_mode = MODE_STEP;
    logic signed [DATA_W-1:0] in_angle = '0;
    logic signed [DATA_W-1:0] in_rate = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [DATA_W-1:0] out_angle;
    logic signed [DATA_W-1:0] out_rate;
    logic                     cfg_we = 1'b0;
    logic [IDX_W-1:0]         cfg_addr = '0;
    logic [CFG_W-1:0]         cfg_data = '0;

    t_pend_item  stim_q[$];
    t_pend_state state_q[$];
    t_pend_item  cur_item;

    // predictor copy of registers and state
    longint m_stiff, m_damp, m_dt, m_en, m_angle, m_rate;

    int  n_err = 0;
    int  n_steps = 0;
    int  n_loads = 0;
    int  n_held = 0;
    int  n_phases = 0;
    int  wdog = 0;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  hold_left = 0;
    bit  hold_req = 1'b0;
    bit  no_idle = 1'b0;
    bit  in_taken = 1'b0;
    bit  out_taken = 1'b0;

    damped_pendulum_rk4_step dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_mode(in_mode), .i_new_angle(in_angle), .i_new_rate(in_rate),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_angle(out_angle), .o_rate(out_rate),
        .i_cfg_wr_en(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_wdata(cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return (a * b) >>> FRAC_W;
    endfunction

    function automatic longint floor_by6(input longint v);
        if (v >= 0) return v / 6;
        return -((-v + 5) / 6);
    endfunction

    // taylor sine on a phase in turns, q2.30 internally
    function automatic longint sine_fix(input longint a);
        longint unsigned p, r, x, x2, t, s;
        logic [31:0] u;
        p = a * 64'sd683565276;
        u = p[FRAC_W+31:FRAC_W];
        r = u[29:0];
        if (u[30]) r = (64'd1 << 30) - r;
        x = (r * 64'd1686629713) >> 30;
        x2 = (x * x) >> 30;
        t = (64'd1 << 30) - x2 / 110;
        t = (64'd1 << 30) - ((x2 * t) >> 30) / 72;
        t = (64'd1 << 30) - ((x2 * t) >> 30) / 42;
        t = (64'd1 << 30) - ((x2 * t) >> 30) / 20;
        t = (64'd1 << 30) - ((x2 * t) >> 30) / 6;
        s = (x * t) >> 30;
        s = (s + 64'd32) >> SIN_SH;
        return u[31] ? -longint'(s) : longint'(s);
    endfunction

    function automatic void slope_terms(input longint a, input longint r,
                                        output longint ka, output longint kr);
        longint dr;
        dr = clamp32(-2 * qmul(m_damp, r) - qmul(m_stiff, sine_fix(a)));
        ka = clamp32(qmul(r, m_dt));
        kr = clamp32(qmul(dr, m_dt));
    endfunction

    function automatic void pendulum_apply(input t_pend_item it);
        longint a, r, ka1, kr1, ka2, kr2, ka3, kr3, ka4, kr4;
        a = m_angle;
        r = m_rate;
        if (it.mode == MODE_LOAD) begin
            m_angle = it.ang;
            m_rate = it.rt;
            n_loads++;
        end else if (m_en != 0) begin
            slope_terms(a, r, ka1, kr1);
            slope_terms(clamp32(a + (ka1 >>> 1)), clamp32(r + (kr1 >>> 1)), ka2, kr2);
            slope_terms(clamp32(a + (ka2 >>> 1)), clamp32(r + (kr2 >>> 1)), ka3, kr3);
            slope_terms(clamp32(a + ka3), clamp32(r + kr3), ka4, kr4);
            m_angle = clamp32(a + floor_by6(ka1 + 2 * ka2 + 2 * ka3 + ka4));
            m_rate = clamp32(r + floor_by6(kr1 + 2 * kr2 + 2 * kr3 + kr4));
            n_steps++;
        end else begin
            n_held++;
        end
        state_q.push_back('{ang: m_angle[DATA_W-1:0], rt: m_rate[DATA_W-1:0]});
    endfunction

    // input side
    always @(negedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_taken) begin
                // offered transaction still stalled, hold it
            end else if (in_valid && in_taken && !no_idle && $urandom_range(0, 9) != 0) begin
                in_valid <= 1'b0;
                send_gap = $urandom_range(0, 8);
            end else if (send_gap > 0 && !in_valid) begin
                send_gap--;
            end else if (stim_q.size() > 0) begin
                cur_item = stim_q.pop_front();
                in_valid <= 1'b1;
                in_mode <= cur_item.mode;
                in_angle <= cur_item.ang;
                in_rate <= cur_item.rt;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result side
    always @(negedge clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_LEN;
        end
        if (out_taken && !no_idle) recv_gap = $urandom_range(0, 9);
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (recv_gap > 0) begin
            recv_gap--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        t_pend_state want;
        in_taken <= in_valid && !in_stall;
        out_taken <= out_valid && !out_stall;
        if (rst_n && in_valid && !in_stall) pendulum_apply(cur_item);
        if (rst_n && out_valid && !out_stall) begin
            if (state_q.size() == 0) begin
                $display("%0t: result with nothing expected: angle %h rate %h",
                         $realtime, out_angle, out_rate);
                n_err++;
            end else begin
                want = state_q.pop_front();
                if (out_angle !== want.ang) begin
                    $display("%0t: angle expected %h actual %h", $realtime, want.ang, out_angle);
                    n_err++;
                end
                if (out_rate !== want.rt) begin
                    $display("%0t: rate expected %h actual %h", $realtime, want.rt, out_rate);
                    n_err++;
                end
            end
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) wdog = 0;
        else wdog++;
        if (wdog >= WDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", state_q.size());
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic reg_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        case (idx)
            CFG_STIFF:   m_stiff = val;
            CFG_DAMPING: m_damp = val;
            CFG_DT:      m_dt = val[DT_W-1:0];
            CFG_ENABLED: m_en = val[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_all(input logic [CFG_W-1:0] st, input logic [CFG_W-1:0] dm,
                           input logic [DT_W-1:0] dt, input bit en);
        // junk above the field width must be dropped
        reg_write(CFG_STIFF, st);
        reg_write(CFG_DAMPING, dm);
        reg_write(CFG_DT, {7'($urandom), dt});
        reg_write(CFG_ENABLED, {30'($urandom), en});
    endtask

    task automatic push_item(input logic md, input logic [DATA_W-1:0] a,
                             input logic [DATA_W-1:0] r);
        stim_q.push_back('{mode: md, ang: a, rt: r});
    endtask

    task automatic drain();
        wait (stim_q.size() == 0 && !in_valid && state_q.size() == 0);
        repeat (120) @(posedge clk);
        n_phases++;
    endtask

    task automatic random_items(input int cnt);
        int sel;
        for (int k = 0; k < cnt; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 78) push_item(MODE_STEP, $urandom, $urandom);
            else if (sel < 93)
                push_item(MODE_LOAD, $urandom_range(0, 32'h0C00_0000) - 32'h0600_0000,
                          $urandom_range(0, 32'h1000_0000) - 32'h0800_0000);
            else push_item(MODE_LOAD, $urandom, $urandom);
        end
    endtask

    initial begin
        m_stiff = 16777216;
        m_damp = 0;
        m_dt = 16777;
        m_en = 0;
        m_angle = 0;
        m_rate = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // defaults: steps hold while disabled, loads still apply
        push_item(MODE_STEP, 32'h7FFF_FFFF, 32'h8000_0000);
        push_item(MODE_LOAD, 32'h7FFF_FFFF, 32'h8000_0000);
        push_item(MODE_STEP, '0, '0);
        push_item(MODE_LOAD, 32'h8000_0000, 32'h7FFF_FFFF);
        drain();

        reg_write(CFG_ENABLED, 31'd1);
        push_item(MODE_STEP, '0, '0);
        push_item(MODE_LOAD, 32'h0100_0000, '0);
        push_item(MODE_STEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_item(MODE_STEP, '0, '0);
        push_item(MODE_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_item(MODE_STEP, '0, '0);
        push_item(MODE_LOAD, 32'h8000_0000, 32'h8000_0000);
        push_item(MODE_STEP, '0, '0);
        push_item(MODE_LOAD, 32'h0324_3F6A, 32'hFE00_0000);
        push_item(MODE_STEP, '0, '0);
        drain();

        // saturation extremes
        set_all(31'h7FFF_FFFF, 31'h7FFF_FFFF, 24'hFF_FFFF, 1'b1);
        push_item(MODE_LOAD, 32'h4000_0000, 32'h7FFF_FFFF);
        push_item(MODE_STEP, '0, '0);
        push_item(MODE_STEP, '0, '0);
        push_item(MODE_LOAD, 32'hC000_0000, 32'h8000_0000);
        push_item(MODE_STEP, '0, '0);
        push_item(MODE_STEP, '0, '0);
        drain();
        set_all('0, '0, '0, 1'b1);
        push_item(MODE_LOAD, 32'h0200_0000, 32'h0100_0000);
        push_item(MODE_STEP, '0, '0);
        drain();

        // long receiver hold-off while the sender keeps offering
        set_all(31'd16777216, 31'd838861, 24'd167772, 1'b1);
        hold_req = 1'b1;
        random_items(150);
        drain();

        for (int ph = 0; ph < 11; ph++) begin
            no_idle = (ph % 4 == 1);
            case ($urandom_range(0, 3))
                0: set_all(CFG_W'($urandom), CFG_W'($urandom), DT_W'($urandom),
                           $urandom_range(0, 7) != 0);
                default: set_all(CFG_W'($urandom_range(0, 31'h6400_0000)),
                                 CFG_W'($urandom_range(0, 31'h0400_0000)),
                                 DT_W'($urandom_range(0, 24'h40_0000)),
                                 $urandom_range(0, 7) != 0);
            endcase
            random_items(150);
            drain();
        end
        no_idle = 1'b0;
        repeat (150) @(posedge clk);

        $display("covered %0d phases: %0d integration steps, %0d loads, %0d held steps",
                 n_phases, n_steps, n_loads, n_held);
        if (n_err == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

endmodule
